### rtl/dtq_pkg.sv
`default_nettype none
package dtq_pkg;

	localparam int SLOTS = 32;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int ORD_W = 6;
	localparam int TIME_W = 32;
	localparam int TAG_W = 8;
	localparam int LEFT_W = 31;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_EXPIRE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FIRED     = 3'd4,
		ST_DONE      = 3'd5,
		ST_NEXT      = 3'd6,
		ST_NONE      = 3'd7
	} status_t;

	// broadcast to every cell for the item in flight
	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now;
		logic [TAG_W-1:0]   tag;
		logic [ORD_W-1:0]   cnt;
	} mode_t;

	// slot update applied at the end of a scan
	typedef struct packed {
		logic               add;
		logic               clr;
		logic [IDX_W-1:0]   idx;
		logic [TIME_W-1:0]  dl;
		logic [TAG_W-1:0]   tag;
		logic               hnd;
		logic [ORD_W-1:0]   order;
	} wr_t;

	// best-so-far candidate handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [IDX_W-1:0]   idx;
		logic [TIME_W-1:0]  dl;
		logic [ORD_W-1:0]   age;
		logic [TAG_W-1:0]   tag;
		logic               hnd;
	} probe_t;

endpackage
`default_nettype wire

### rtl/dtq_cell.sv
`default_nettype none
module dtq_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [dtq_pkg::IDX_W-1:0]  slot_idx,
	input  wire dtq_pkg::mode_t             mode,
	input  wire dtq_pkg::wr_t               wr,
	input  wire dtq_pkg::probe_t            probe_in,
	output dtq_pkg::probe_t                 probe_out
);

	logic                        live_q;
	logic [dtq_pkg::TIME_W-1:0]  dl_q;
	logic [dtq_pkg::TAG_W-1:0]   tag_q;
	logic                        hnd_q;
	logic [dtq_pkg::ORD_W-1:0]   order_q;
	dtq_pkg::probe_t             probe_q;

	logic [dtq_pkg::ORD_W-1:0]   age;
	logic                        take;
	logic                        sel;
	dtq_pkg::probe_t             probe_next;

	assign sel = (wr.idx == slot_idx);

	always_comb begin
		age = mode.cnt - order_q;
		unique case (mode.op)
			dtq_pkg::OP_ADD: begin
				take = !live_q && !probe_in.hit;
			end
			dtq_pkg::OP_CANCEL: begin
				take = live_q && (tag_q == mode.tag) && (!probe_in.hit || age < probe_in.age);
			end
			dtq_pkg::OP_EXPIRE: begin
				take = live_q && (dl_q <= mode.now) && (!probe_in.hit || dl_q < probe_in.dl);
			end
			dtq_pkg::OP_QUERY: begin
				take = live_q && (!probe_in.hit || dl_q < probe_in.dl);
			end
		endcase
	end

	always_comb begin
		probe_next = probe_in;
		if (take) begin
			probe_next.hit = 1'b1;
			probe_next.idx = slot_idx;
			probe_next.dl = dl_q;
			probe_next.age = age;
			probe_next.tag = tag_q;
			probe_next.hnd = hnd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			probe_q <= '0;
		end else begin
			if (wr.add && sel)
				live_q <= 1'b1;
			else if (wr.clr && sel)
				live_q <= 1'b0;
			probe_q <= probe_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.add && sel) begin
			dl_q <= wr.dl;
			tag_q <= wr.tag;
			hnd_q <= wr.hnd;
			order_q <= wr.order;
		end
	end

	assign probe_out = probe_q;

endmodule
`default_nettype wire

### rtl/dtq_ctrl.sv
`default_nettype none
module dtq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire logic [dtq_pkg::TIME_W-1:0]  now_ms,
	input  wire logic [dtq_pkg::TAG_W-1:0]   request_tag,
	input  wire logic [dtq_pkg::TIME_W-1:0]  timeout_ms,
	input  wire logic                        has_handler,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       status,
	output logic [dtq_pkg::TAG_W-1:0]        tag_out,
	output logic [dtq_pkg::LEFT_W-1:0]       time_left_ms,
	output logic                             last,
	output dtq_pkg::mode_t                   mode,
	output dtq_pkg::wr_t                     wr,
	output logic                             launch,
	input  wire dtq_pkg::probe_t             probe_end
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		EMIT
	} state_t;

	state_t                        state_q;
	logic                          launch_q;
	dtq_pkg::op_t                  op_q;
	logic [dtq_pkg::TIME_W-1:0]    now_q;
	logic [dtq_pkg::TAG_W-1:0]     tag_q;
	logic [dtq_pkg::TIME_W-1:0]    dl_q;
	logic                          hnd_q;
	logic [dtq_pkg::ORD_W-1:0]     cnt_q;
	dtq_pkg::probe_t               res_q;
	logic                          out_valid_q;
	dtq_pkg::status_t              status_q;
	logic [dtq_pkg::TAG_W-1:0]     tag_out_q;
	logic [dtq_pkg::LEFT_W-1:0]    left_q;
	logic                          last_q;

	logic [dtq_pkg::TIME_W:0]      sum;
	logic [dtq_pkg::TIME_W-1:0]    add_dl;
	logic [dtq_pkg::TIME_W-1:0]    diff;
	logic [dtq_pkg::LEFT_W-1:0]    left;
	logic                          emit_go;
	logic                          rescan;
	logic                          beat_go;

	always_comb begin
		sum = {1'b0, now_ms} + {1'b0, timeout_ms};
		add_dl = sum[dtq_pkg::TIME_W] ? '1 : sum[dtq_pkg::TIME_W-1:0];
		// clamp at zero when already due, saturate to the 31-bit field
		diff = (res_q.dl > now_q) ? (res_q.dl - now_q) : '0;
		left = diff[dtq_pkg::TIME_W-1] ? '1 : diff[dtq_pkg::LEFT_W-1:0];
	end

	assign emit_go = (state_q == EMIT) && (!out_valid_q || out_ready);
	// a due entry was found: free it and rescan
	assign rescan = emit_go && (op_q == dtq_pkg::OP_EXPIRE) && res_q.hit;
	// a due entry without handler frees its slot but loads no beat
	assign beat_go = emit_go && !(rescan && !res_q.hnd);

	always_comb begin
		wr.add = emit_go && (op_q == dtq_pkg::OP_ADD) && res_q.hit;
		wr.clr = emit_go && res_q.hit &&
			((op_q == dtq_pkg::OP_CANCEL) || (op_q == dtq_pkg::OP_EXPIRE));
		wr.idx = res_q.idx;
		wr.dl = dl_q;
		wr.tag = tag_q;
		wr.hnd = hnd_q;
		wr.order = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			launch_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			op_q <= dtq_pkg::OP_ADD;
			now_q <= '0;
			tag_q <= '0;
			dl_q <= '0;
			hnd_q <= 1'b0;
			res_q <= '0;
			status_q <= dtq_pkg::ST_ADDED;
			tag_out_q <= '0;
			left_q <= '0;
			last_q <= 1'b0;
		end else begin
			launch_q <= ((state_q == IDLE) && in_valid) || rescan;
			if (beat_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						op_q <= dtq_pkg::op_t'(operation);
						now_q <= now_ms;
						tag_q <= request_tag;
						dl_q <= add_dl;
						hnd_q <= has_handler;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (probe_end.valid) begin
						res_q <= probe_end;
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (emit_go) begin
						state_q <= rescan ? SCAN : IDLE;
						last_q <= !rescan;
						unique case (op_q)
							dtq_pkg::OP_ADD: begin
								status_q <= res_q.hit ? dtq_pkg::ST_ADDED : dtq_pkg::ST_FULL;
								tag_out_q <= res_q.hit ? tag_q : '0;
								left_q <= '0;
								if (res_q.hit)
									cnt_q <= cnt_q + 1'b1;
							end
							dtq_pkg::OP_CANCEL: begin
								status_q <= res_q.hit ? dtq_pkg::ST_CANCELLED
									: dtq_pkg::ST_NOT_FOUND;
								tag_out_q <= res_q.hit ? tag_q : '0;
								left_q <= '0;
							end
							dtq_pkg::OP_QUERY: begin
								status_q <= res_q.hit ? dtq_pkg::ST_NEXT : dtq_pkg::ST_NONE;
								tag_out_q <= '0;
								left_q <= res_q.hit ? left : '0;
							end
							dtq_pkg::OP_EXPIRE: begin
								left_q <= '0;
								if (res_q.hit) begin
									if (res_q.hnd) begin
										status_q <= dtq_pkg::ST_FIRED;
										tag_out_q <= res_q.tag;
									end
								end else begin
									status_q <= dtq_pkg::ST_DONE;
									tag_out_q <= '0;
								end
							end
						endcase
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign tag_out = tag_out_q;
	assign time_left_ms = left_q;
	assign last = last_q;
	assign launch = launch_q;

	always_comb begin
		mode.op = op_q;
		mode.now = now_q;
		mode.tag = tag_q;
		mode.cnt = cnt_q;
	end

endmodule
`default_nettype wire

### rtl/deadline_timer_queue_unit.sv
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_ready  | operation, now_ms, request_tag, timeout_ms, has_handler
// out     | out_valid/ out_ready | status, tag_out, time_left_ms, last
//
// One item at a time. A probe walks the cell row, one cell per cycle, and the
// result is taken at the end of the row; add, cancel and query scan it once.
// Expire rescans after each due entry until no due entry is left.
// Reset empties every slot at once; no clearing pass.
// A stalled output holds the queue in its emit step; the next item is taken
// as soon as the last beat of the current one is registered.
module deadline_timer_queue_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire logic [dtq_pkg::TIME_W-1:0]  now_ms,
	input  wire logic [dtq_pkg::TAG_W-1:0]   request_tag,
	input  wire logic [dtq_pkg::TIME_W-1:0]  timeout_ms,
	input  wire logic                        has_handler,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       status,
	output logic [dtq_pkg::TAG_W-1:0]        tag_out,
	output logic [dtq_pkg::LEFT_W-1:0]       time_left_ms,
	output logic                             last
);

	dtq_pkg::mode_t   mode;
	dtq_pkg::wr_t     wr;
	logic             launch;
	dtq_pkg::probe_t  chain [dtq_pkg::SLOTS+1];

	always_comb begin
		chain[0] = '0;
		chain[0].valid = launch;
	end

	for (genvar i = 0; i < dtq_pkg::SLOTS; i++) begin : g_cell
		dtq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot_idx  (dtq_pkg::IDX_W'(i)),
			.mode      (mode),
			.wr        (wr),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1])
		);
	end

	dtq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.now_ms       (now_ms),
		.request_tag  (request_tag),
		.timeout_ms   (timeout_ms),
		.has_handler  (has_handler),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.tag_out      (tag_out),
		.time_left_ms (time_left_ms),
		.last         (last),
		.mode         (mode),
		.wr           (wr),
		.launch       (launch),
		.probe_end    (chain[dtq_pkg::SLOTS])
	);

endmodule
`default_nettype wire

### test/deadline_timer_queue_unit_test.sv
`default_nettype none
module deadline_timer_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtq_pkg::*;

	localparam int TICK_MS = 1000;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct {
		status_t            status;
		logic [TAG_W-1:0]   tag;
		logic [LEFT_W-1:0]  left;
		logic               last;
	} reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          operation = '0;
	logic [TIME_W-1:0]   now_ms = '0;
	logic [TAG_W-1:0]    request_tag = '0;
	logic [TIME_W-1:0]   timeout_ms = '0;
	logic                has_handler = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          status;
	logic [TAG_W-1:0]    tag_out;
	logic [LEFT_W-1:0]   time_left_ms;
	logic                last;

	// shadow copy of the timer table
	logic [TIME_W-1:0]   slot_deadline [SLOTS];
	logic [TAG_W-1:0]    slot_tag [SLOTS];
	logic                slot_handler [SLOTS];
	logic                slot_busy [SLOTS] = '{default: 1'b0};
	logic [ORD_W-1:0]    slot_stamp [SLOTS];
	logic [ORD_W-1:0]    next_stamp = '0;

	reply_t              timer_replies [$];
	logic [TIME_W-1:0]   wall_ms = '0;
	int                  burst_left = 0;
	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  ready_mode = 0;
	int                  mode_left = 0;

	deadline_timer_queue_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.now_ms(now_ms),
		.request_tag(request_tag),
		.timeout_ms(timeout_ms),
		.has_handler(has_handler),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.tag_out(tag_out),
		.time_left_ms(time_left_ms),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: switches between always ready, random, sparse and toggling
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(3);
			mode_left = $urandom_range(10, 80);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(1) == 1);
			2: out_ready <= ($urandom_range(3) == 0);
			default: out_ready <= ~out_ready;
		endcase
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (timer_replies.size() == 0) begin
				$error("unexpected beat: status %0d tag_out %0d", status, tag_out);
				mismatches++;
			end else begin
				want = timer_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %s, got %0d", want.status.name(), status);
					mismatches++;
				end
				if (tag_out !== want.tag) begin
					$error("tag_out: expected %0d, got %0d", want.tag, tag_out);
					mismatches++;
				end
				if (time_left_ms !== want.left) begin
					$error("time_left_ms: expected %0d, got %0d", want.left, time_left_ms);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	function automatic void push_reply(input status_t st, input logic [TAG_W-1:0] tag,
			input logic [LEFT_W-1:0] left, input logic fin);
		reply_t r;
		r.status = st;
		r.tag = tag;
		r.left = left;
		r.last = fin;
		timer_replies.push_back(r);
	endfunction

	// earliest live deadline, lowest slot on ties; -1 if none
	function automatic int earliest_slot(input bit due_only, input logic [TIME_W-1:0] now);
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i] && !(due_only && slot_deadline[i] > now)) begin
				if (best < 0 || slot_deadline[i] < slot_deadline[best])
					best = i;
			end
		end
		return best;
	endfunction

	function automatic void apply_timer_op(input op_t op, input logic [TIME_W-1:0] now,
			input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] tmo, input logic hnd);
		int best;
		logic [ORD_W-1:0] age;
		logic [ORD_W-1:0] best_age;
		logic [TIME_W:0] sum;
		logic [TIME_W-1:0] diff;
		best = -1;
		best_age = '0;
		case (op)
			OP_ADD: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!slot_busy[i])
						best = i;
				if (best < 0) begin
					push_reply(ST_FULL, '0, '0, 1'b1);
				end else begin
					sum = {1'b0, now} + {1'b0, tmo};
					slot_deadline[best] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
					slot_tag[best] = tag;
					slot_handler[best] = hnd;
					slot_stamp[best] = next_stamp;
					slot_busy[best] = 1'b1;
					next_stamp = next_stamp + 1'b1;
					push_reply(ST_ADDED, tag, '0, 1'b1);
				end
			end
			OP_CANCEL: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_busy[i] && slot_tag[i] == tag) begin
						age = next_stamp - slot_stamp[i];
						if (best < 0 || age < best_age) begin
							best = i;
							best_age = age;
						end
					end
				end
				if (best < 0) begin
					push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					slot_busy[best] = 1'b0;
					push_reply(ST_CANCELLED, tag, '0, 1'b1);
				end
			end
			OP_EXPIRE: begin
				best = earliest_slot(1'b1, now);
				while (best >= 0) begin
					slot_busy[best] = 1'b0;
					if (slot_handler[best])
						push_reply(ST_FIRED, slot_tag[best], '0, 1'b0);
					best = earliest_slot(1'b1, now);
				end
				push_reply(ST_DONE, '0, '0, 1'b1);
			end
			default: begin
				best = earliest_slot(1'b0, now);
				if (best < 0) begin
					push_reply(ST_NONE, '0, '0, 1'b1);
				end else begin
					diff = (slot_deadline[best] > now) ? slot_deadline[best] - now : '0;
					if (diff[TIME_W-1])
						push_reply(ST_NEXT, '0, '1, 1'b1);
					else
						push_reply(ST_NEXT, '0, diff[LEFT_W-1:0], 1'b1);
				end
			end
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_live_tag();
		int n;
		int k;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_busy[i])
				n++;
		if (n == 0)
			return TAG_W'($urandom_range(255));
		k = $urandom_range(n - 1);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i]) begin
				if (k == 0)
					return slot_tag[i];
				k--;
			end
		end
		return '0;
	endfunction

	// valid stays high across back-to-back beats; it only drops for a gap
	task automatic send_item(input op_t op, input logic [TIME_W-1:0] now,
			input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] tmo, input logic hnd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		operation <= op;
		now_ms <= now;
		request_tag <= tag;
		timeout_ms <= tmo;
		has_handler <= hnd;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		apply_timer_op(op, now, tag, tmo, hnd);
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (timer_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_item(OP_QUERY, '0, '0, '0, 1'b0);
		send_item(OP_CANCEL, 32'd5, 8'h5a, '0, 1'b0);
		send_item(OP_EXPIRE, '1, '0, '0, 1'b0);
	endtask

	task automatic test_time_limits();
		send_item(OP_ADD, '0, 8'haa, 32'hffff_fff0, 1'b1);
		// remaining time beyond 31 bits saturates
		send_item(OP_QUERY, '0, '0, '0, 1'b0);
		// now + timeout overflows, deadline pins at the top
		send_item(OP_ADD, '1, 8'hff, '1, 1'b0);
		send_item(OP_ADD, 32'd100, 8'h00, '0, 1'b1);
		// overdue deadline clamps to zero
		send_item(OP_QUERY, 32'd200, '0, '0, 1'b0);
		send_item(OP_QUERY, 32'd50, '0, '0, 1'b0);
		send_item(OP_EXPIRE, '1, '0, '0, 1'b0);
	endtask

	task automatic test_cancel_newest();
		send_item(OP_ADD, 32'd1000, 8'd5, 32'd3000, 1'b1);
		send_item(OP_ADD, 32'd1000, 8'd5, 32'd2000, 1'b1);
		send_item(OP_ADD, 32'd1000, 8'd9, 32'd3000, 1'b1);
		send_item(OP_ADD, 32'd1000, 8'd5, 32'd5000, 1'b0);
		send_item(OP_CANCEL, 32'd1100, 8'd5, '0, 1'b0);
		send_item(OP_CANCEL, 32'd1100, 8'd7, '0, 1'b0);
		send_item(OP_ADD, 32'd1200, 8'h80, '0, 1'b1);
		send_item(OP_EXPIRE, 32'd3000, '0, '0, 1'b0);
		send_item(OP_QUERY, 32'd3500, '0, '0, 1'b0);
		// equal deadlines: lower slot fires first
		send_item(OP_EXPIRE, 32'd4000, '0, '0, 1'b0);
		send_item(OP_CANCEL, 32'd4000, 8'd5, '0, 1'b0);
	endtask

	task automatic test_full_table();
		logic [TIME_W-1:0] base;
		base = $urandom_range(100000);
		send_item(OP_EXPIRE, '1, '0, '0, 1'b0);
		for (int i = 0; i < SLOTS; i++)
			send_item(OP_ADD, base, TAG_W'($urandom_range(255)),
				$urandom_range(3) * TICK_MS, 1'b1);
		send_item(OP_ADD, base, 8'h42, 32'd10, 1'b1);
		send_item(OP_QUERY, base + 1, '0, '0, 1'b0);
		send_item(OP_CANCEL, base + 1, 8'h42, '0, 1'b0);
		send_item(OP_EXPIRE, base + 4 * TICK_MS, '0, '0, 1'b0);
		wall_ms = base + 4 * TICK_MS;
	endtask

	// 64 adds wrap the stamp while the first entry stays live; a cancel then
	// sees two entries of the same age and must take the lower slot
	task automatic test_stamp_wrap();
		logic [TAG_W-1:0] owner;
		logic [TIME_W-1:0] base;
		owner = TAG_W'($urandom_range(255));
		base = $urandom_range(1000000);
		send_item(OP_EXPIRE, '1, '0, '0, 1'b0);
		send_item(OP_ADD, base, owner, 32'h4000_0000, 1'b1);
		for (int i = 0; i < 63; i++) begin
			send_item(OP_ADD, base, TAG_W'(owner + 8'd1 + $urandom_range(254)),
				$urandom_range(3 * TICK_MS), 1'($urandom_range(1)));
			if (i % 31 == 30 || i == 62)
				send_item(OP_EXPIRE, base + 4 * TICK_MS, '0, '0, 1'b0);
		end
		send_item(OP_ADD, base, owner, TICK_MS / 2, 1'($urandom_range(1)));
		send_item(OP_CANCEL, base + 1, owner, '0, 1'b0);
		send_item(OP_QUERY, base + 1, '0, '0, 1'b0);
		send_item(OP_CANCEL, base + 1, owner, '0, 1'b0);
		send_item(OP_CANCEL, base + 1, owner, '0, 1'b0);
		wall_ms = base + 1;
	endtask

	task automatic random_timer_op(input int add_pct);
		int pick;
		op_t op;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] tmo;
		logic [TAG_W-1:0] tag;
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			op = OP_ADD;
		end else begin
			case ((pick - add_pct) % 3)
				0: op = OP_CANCEL;
				1: op = OP_EXPIRE;
				default: op = OP_QUERY;
			endcase
		end
		pick = $urandom_range(19);
		if (pick == 0)
			wall_ms = $urandom();
		else
			wall_ms = wall_ms + $urandom_range(2 * TICK_MS);
		now = (pick == 1) ? $urandom() : wall_ms;
		if (op == OP_CANCEL && $urandom_range(3) != 0)
			tag = pick_live_tag();
		else if ($urandom_range(9) < 7)
			tag = TAG_W'($urandom_range(7));
		else
			tag = TAG_W'($urandom_range(255));
		case ($urandom_range(9))
			0: tmo = $urandom();
			1, 2, 3: tmo = $urandom_range(5 * TICK_MS);
			default: tmo = $urandom_range(4) * TICK_MS + $urandom_range(1);
		endcase
		send_item(op, now, tag, tmo, 1'($urandom_range(1)));
	endtask

	task automatic test_random_traffic();
		int add_pct;
		for (int round = 0; round < 4; round++) begin
			if (round == 2)
				add_pct = 90;
			else
				add_pct = (round % 2 == 1) ? 60 : 35;
			for (int i = 0; i < 20; i++)
				random_timer_op(add_pct);
			if (round == 1)
				wait_for_replies();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_time_limits();
		wait_for_replies();
		test_cancel_newest();
		test_full_table();
		wait_for_replies();
		test_stamp_wrap();
		test_random_traffic();
		wait_for_replies();
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/dtq_ctrl.sv
rtl/deadline_timer_queue_unit.sv
test/deadline_timer_queue_unit_test.sv
